[sv/gha_pkg.sv]
// Shared types and constants for the GHASH accumulator.
package gha_pkg;

    localparam int unsigned BLK_W    = 128;
    localparam int unsigned HALF_W   = 64;
    localparam int unsigned DIGIT_W  = 16;
    localparam int unsigned DIGITS   = BLK_W / DIGIT_W;
    localparam int unsigned DCNT_W   = $clog2(DIGITS);
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned BCNT_W   = 5;
    localparam int unsigned BYTES    = BLK_W / 8;

    localparam logic [7:0] RED_POLY = 8'he1;

    // request kinds
    localparam logic [1:0] KIND_HDR  = 2'd0;
    localparam logic [1:0] KIND_BODY = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;

    // configuration register indexes
    localparam logic CFG_KEY_HI = 1'b0;
    localparam logic CFG_KEY_LO = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;     // start a block: build operand, update counts
        logic finish;   // operand is the length block, clear counts
        logic is_body;  // count into body bytes
        logic step;     // one digit of the multiply
        logic last;     // final digit: write accumulator
        logic emit;     // move accumulator to output, clear it
    } t_cmd;

endpackage

[sv/gha_ctrl.sv]
// Sequencer for the GHASH accumulator: handshakes, digit count, output flag.
module gha_ctrl
    import gha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [BCNT_W-1:0] i_byte_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_cmd              o_cmd
);

    t_state              r_state, n_state;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic                r_fin, n_fin;
    logic                r_out_valid, n_out_valid;
    logic                accept;
    logic                out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_dcnt      <= '0;
            r_fin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dcnt      <= n_dcnt;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_dcnt      = r_dcnt;
        n_fin       = r_fin;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        accept      = 1'b0;
        out_free    = ~r_out_valid | i_out_ready;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                accept     = i_in_valid;
                if (accept) begin
                    if (i_kind == KIND_FIN) begin
                        o_cmd.load   = 1'b1;
                        o_cmd.finish = 1'b1;
                        n_fin        = 1'b1;
                        n_dcnt       = '0;
                        n_state      = ST_MUL;
                    end else if ((i_kind == KIND_HDR || i_kind == KIND_BODY)
                                 && i_byte_count != '0) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.is_body = (i_kind == KIND_BODY);
                        n_fin         = 1'b0;
                        n_dcnt        = '0;
                        n_state       = ST_MUL;
                    end
                    // unused kind or empty block: drop
                end
            end
            ST_MUL: begin
                o_cmd.step = 1'b1;
                n_dcnt     = r_dcnt + 1'b1;
                if (r_dcnt == DCNT_W'(DIGITS - 1)) begin
                    o_cmd.last = 1'b1;
                    n_state    = r_fin ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

[sv/gha_dp.sv]
// Datapath for the GHASH accumulator: subkey, accumulator, counts, digit-serial multiplier.
module gha_dp
    import gha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [HALF_W-1:0] i_block_high,
    input  logic [HALF_W-1:0] i_block_low,
    input  logic [BCNT_W-1:0] i_byte_count,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [HALF_W-1:0] i_cfg_data,
    output logic [HALF_W-1:0] o_digest_high,
    output logic [HALF_W-1:0] o_digest_low
);

    logic [HALF_W-1:0] r_key_hi, r_key_lo;
    logic [BLK_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_hdr, n_hdr;
    logic [CNT_W-1:0]  r_body, n_body;
    logic [BLK_W-1:0]  r_x, n_x;
    logic [BLK_W-1:0]  r_v, n_v;
    logic [BLK_W-1:0]  r_z, n_z;
    logic [BLK_W-1:0]  r_out;

    logic [BCNT_W-1:0] nbytes;
    logic [BLK_W-1:0]  mask;
    logic [BLK_W-1:0]  operand;
    logic [CNT_W:0]    hsum, bsum;
    logic [BLK_W-1:0]  dv, dz;
    logic              carry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_acc    <= '0;
            r_hdr    <= '0;
            r_body   <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_KEY_HI) r_key_hi <= i_cfg_data;
            if (i_cfg_we && i_cfg_index == CFG_KEY_LO) r_key_lo <= i_cfg_data;
            r_acc  <= n_acc;
            r_hdr  <= n_hdr;
            r_body <= n_body;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_v <= n_v;
        r_z <= n_z;
        if (i_cmd.emit) r_out <= r_acc;
    end

    // one 16-bit digit of X against V: msb of X first, V walks by one bit per step
    always_comb begin
        dv    = r_v;
        dz    = r_z;
        carry = 1'b0;
        for (int k = 0; k < DIGIT_W; k++) begin
            if (r_x[BLK_W-1-k]) dz = dz ^ dv;
            carry = dv[0];
            dv    = {1'b0, dv[BLK_W-1:1]};
            if (carry) dv[BLK_W-1 -: 8] = dv[BLK_W-1 -: 8] ^ RED_POLY;
        end
    end

    always_comb begin
        nbytes = (i_byte_count > BCNT_W'(BYTES)) ? BCNT_W'(BYTES) : i_byte_count;
        for (int j = 0; j < BYTES; j++) begin
            mask[BLK_W-1-8*j -: 8] = (BCNT_W'(j) < nbytes) ? 8'hff : 8'h00;
        end
        hsum = {1'b0, r_hdr} + (CNT_W+1)'(nbytes);
        bsum = {1'b0, r_body} + (CNT_W+1)'(nbytes);
        if (i_cmd.finish) begin
            operand = {29'd0, r_hdr, 3'd0, 29'd0, r_body, 3'd0};
        end else begin
            operand = {i_block_high, i_block_low} & mask;
        end

        n_acc  = r_acc;
        n_hdr  = r_hdr;
        n_body = r_body;
        n_x    = r_x;
        n_v    = r_v;
        n_z    = r_z;

        if (i_cmd.load) begin
            n_x = r_acc ^ operand;
            n_v = {r_key_hi, r_key_lo};
            n_z = '0;
            if (i_cmd.finish) begin
                n_hdr  = '0;
                n_body = '0;
            end else if (i_cmd.is_body) begin
                n_body = bsum[CNT_W] ? '1 : bsum[CNT_W-1:0];
            end else begin
                n_hdr = hsum[CNT_W] ? '1 : hsum[CNT_W-1:0];
            end
        end
        if (i_cmd.step) begin
            n_x = {r_x[BLK_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            n_v = dv;
            n_z = dz;
        end
        if (i_cmd.last) n_acc = dz;
        if (i_cmd.emit) n_acc = '0;
    end

    assign o_digest_high = r_out[BLK_W-1 -: HALF_W];
    assign o_digest_low  = r_out[HALF_W-1:0];

endmodule

[sv/ghash_accumulator.sv]
// GHASH accumulator top level: sequencer plus multiply datapath.
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | i_kind, i_block_high, i_block_low, i_byte_count
//   out     | output    | o_out_valid / i_out_ready | o_digest_high, o_digest_low
//   cfg     | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// A header or body block is accepted in the idle state and then runs digit by digit
// through the 128x16 digit-serial GF(2^128) multiplier. A finish request also runs
// the multiply, then an emit state loads the digest when the output register is free.
// Dropped requests (empty block, unused kind) are accepted and start no multiply.
// A waiting digest stalls only a following finish request, which holds in the emit
// state and blocks the input until the waiting digest is taken.
// Reset is synchronous, active low, and clears subkey, accumulator and counts.
module ghash_accumulator
    import gha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [HALF_W-1:0] i_block_high,
    input  logic [HALF_W-1:0] i_block_low,
    input  logic [BCNT_W-1:0] i_byte_count,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [HALF_W-1:0] o_digest_high,
    output logic [HALF_W-1:0] o_digest_low,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [HALF_W-1:0] i_cfg_data
);

    t_cmd cmd;

    gha_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_byte_count (i_byte_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cmd        (cmd)
    );

    gha_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_block_high  (i_block_high),
        .i_block_low   (i_block_low),
        .i_byte_count  (i_byte_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_digest_high (o_digest_high),
        .o_digest_low  (o_digest_low)
    );

endmodule

[sv/ghash_accumulator_chk.sv]
// Port-level checks for the GHASH accumulator, bound to the top level.
module ghash_accumulator_chk
    import gha_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              o_in_ready,
    input  logic [1:0]        i_kind,
    input  logic [BCNT_W-1:0] i_byte_count,
    input  logic              o_out_valid,
    input  logic              i_out_ready,
    input  logic [HALF_W-1:0] o_digest_high,
    input  logic [HALF_W-1:0] o_digest_low
);

    logic data_acc;
    assign data_acc = i_in_valid && o_in_ready && i_byte_count != '0
                      && (i_kind == KIND_HDR || i_kind == KIND_BODY);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_digest_high) && $stable(o_digest_low))
        else $error("digest changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        data_acc |-> ##8 !o_in_ready)
        else $error("block multiply ended early");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        data_acc |-> ##9 o_in_ready)
        else $error("block multiply did not return to idle");

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("digest appeared while idle");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind ghash_accumulator ghash_accumulator_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_kind        (i_kind),
    .i_byte_count  (i_byte_count),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_digest_high (o_digest_high),
    .o_digest_low  (o_digest_low)
);

[tb/tb_top.sv]
// Self-checking testbench for the GHASH accumulator: predicted digests vs. DUT output.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gha_pkg::*;

    localparam logic [1:0] KIND_RSVD  = 2'd3;
    localparam int unsigned SETTLE    = 24;
    localparam int unsigned MAX_CYCLES = 400000;
    localparam int unsigned RAND_ITEMS = 750;

    typedef struct packed {
        logic [HALF_W-1:0] hi;
        logic [HALF_W-1:0] lo;
    } t_digest;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        in_kind = KIND_HDR;
    logic [HALF_W-1:0] in_block_high = '0;
    logic [HALF_W-1:0] in_block_low = '0;
    logic [BCNT_W-1:0] in_byte_count = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [HALF_W-1:0] digest_high;
    logic [HALF_W-1:0] digest_low;
    logic              cfg_we = 1'b0;
    logic              cfg_index = CFG_KEY_HI;
    logic [HALF_W-1:0] cfg_data = '0;

    // predictor state
    logic [BLK_W-1:0]  hash_key = '0;
    logic [BLK_W-1:0]  acc_sum = '0;
    logic [CNT_W-1:0]  hdr_count = '0;
    logic [CNT_W-1:0]  body_count = '0;

    t_digest           digest_q[$];
    t_digest           want;
    int unsigned       hashed_items = 0;
    int unsigned       failures = 0;
    int unsigned       cycle_count = 0;
    bit                idle_on = 1'b1;

    ghash_accumulator dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_kind       (in_kind),
        .i_block_high (in_block_high),
        .i_block_low  (in_block_low),
        .i_byte_count (in_byte_count),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_digest_high(digest_high),
        .o_digest_low (digest_low),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("[ghash_accumulator] ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_ready <= idle_on ? ($urandom_range(99) >= 14) : 1'b1;
    end

    // Compare every accepted digest with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (digest_q.size() == 0) begin
                $error("unexpected digest %h_%h", digest_high, digest_low);
                failures++;
            end else begin
                want = digest_q.pop_front();
                if (digest_high !== want.hi) begin
                    $error("digest_high: expected %h, got %h", want.hi, digest_high);
                    failures++;
                end
                if (digest_low !== want.lo) begin
                    $error("digest_low: expected %h, got %h", want.lo, digest_low);
                    failures++;
                end
            end
        end
    end

    // Carry-less product in GF(2^128), bit 127 holds the first bit of the block.
    function automatic logic [BLK_W-1:0] gf128_mul(input logic [BLK_W-1:0] x,
                                                   input logic [BLK_W-1:0] y);
        logic [BLK_W-1:0] z;
        logic [BLK_W-1:0] v;
        logic             carry;
        z = '0;
        v = y;
        for (int k = 0; k < BLK_W; k++) begin
            if (x[BLK_W-1-k]) z ^= v;
            carry = v[0];
            v = v >> 1;
            if (carry) v[BLK_W-1 -: 8] ^= RED_POLY;
        end
        return z;
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input int unsigned n);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(n);
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // Update the hash state for one accepted request; queue a digest on finish.
    function automatic void ghash_predict(input logic [1:0] kind,
                                          input logic [HALF_W-1:0] bh,
                                          input logic [HALF_W-1:0] bl,
                                          input logic [BCNT_W-1:0] cnt);
        logic [BLK_W-1:0] keep;
        int unsigned      n;
        t_digest          d;
        n = (cnt > BYTES) ? BYTES : cnt;
        if (kind == KIND_FIN) begin
            acc_sum = gf128_mul(acc_sum ^ {29'b0, hdr_count, 3'b0, 29'b0, body_count, 3'b0},
                                hash_key);
            d.hi = acc_sum[BLK_W-1:HALF_W];
            d.lo = acc_sum[HALF_W-1:0];
            digest_q.push_back(d);
            acc_sum = '0;
            hdr_count = '0;
            body_count = '0;
            hashed_items++;
        end else if ((kind == KIND_HDR || kind == KIND_BODY) && n != 0) begin
            keep = {BLK_W{1'b1}} << (8 * (BYTES - n));
            acc_sum = gf128_mul(acc_sum ^ ({bh, bl} & keep), hash_key);
            if (kind == KIND_HDR) hdr_count = sat_add(hdr_count, n);
            else body_count = sat_add(body_count, n);
            hashed_items++;
        end
    endfunction

    function automatic logic [HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Present one request and hold it until accepted; valid stays high on return.
    task automatic send_request(input logic [1:0] kind, input logic [HALF_W-1:0] bh,
                                input logic [HALF_W-1:0] bl, input logic [BCNT_W-1:0] cnt);
        while (idle_on && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_kind       <= kind;
        in_block_high <= bh;
        in_block_low  <= bl;
        in_byte_count <= cnt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        ghash_predict(kind, bh, bl, cnt);
    endtask

    // Drop valid, drain all digests, then let any block still in the multiplier finish.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [HALF_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY_HI) hash_key[BLK_W-1:HALF_W] = data;
        else hash_key[HALF_W-1:0] = data;
        @(posedge clk);
    endtask

    task automatic set_subkey(input logic [BLK_W-1:0] key);
        wait_idle();
        write_cfg(CFG_KEY_HI, key[BLK_W-1:HALF_W]);
        write_cfg(CFG_KEY_LO, key[HALF_W-1:0]);
    endtask

    // Odd requests in the middle of a message: dropped, oversized, or body blocks of 1 to 16 bytes.
    task automatic send_noise();
        case ($urandom_range(3))
            0: send_request($urandom_range(1) ? KIND_BODY : KIND_HDR, rand64(), rand64(), '0);
            1: send_request(KIND_RSVD, rand64(), rand64(), BCNT_W'($urandom));
            2: send_request(KIND_HDR, rand64(), rand64(), BCNT_W'($urandom_range(17, 31)));
            default: send_request(KIND_BODY, rand64(), rand64(), BCNT_W'($urandom_range(1, 16)));
        endcase
    endtask

    task automatic send_message(input int n_hdr, input int n_body);
        logic [BCNT_W-1:0] cnt;
        for (int i = 0; i < n_hdr; i++) begin
            cnt = (i == n_hdr - 1 && $urandom_range(1)) ? BCNT_W'($urandom_range(1, 16))
                                                        : BCNT_W'(BYTES);
            send_request(KIND_HDR, rand64(), rand64(), cnt);
            if ($urandom_range(99) < 6) send_noise();
        end
        for (int i = 0; i < n_body; i++) begin
            cnt = (i == n_body - 1 && $urandom_range(1)) ? BCNT_W'($urandom_range(1, 16))
                                                         : BCNT_W'(BYTES);
            send_request(KIND_BODY, rand64(), rand64(), cnt);
            if ($urandom_range(99) < 6) send_noise();
        end
        // header after body is hashed as header all the same
        if ($urandom_range(99) < 8)
            send_request(KIND_HDR, rand64(), rand64(), BCNT_W'($urandom_range(1, 16)));
        send_request(KIND_FIN, rand64(), rand64(), BCNT_W'($urandom));
    endtask

    task automatic test_directed();
        // subkey still at its reset value: an empty message hashes to zero
        send_request(KIND_FIN, '0, '0, '0);
        set_subkey({rand64(), rand64()});
        send_request(KIND_HDR, '1, '1, 5'd16);
        send_request(KIND_HDR, '1, '1, 5'd1);
        send_request(KIND_HDR, '1, '1, 5'd0);
        send_request(KIND_BODY, '1, '1, 5'd8);
        send_request(KIND_BODY, '1, '1, 5'd9);
        send_request(KIND_BODY, rand64(), rand64(), 5'd15);
        send_request(KIND_BODY, rand64(), rand64(), 5'd31);
        send_request(KIND_BODY, rand64(), rand64(), 5'd17);
        send_request(KIND_RSVD, '1, '1, 5'd16);
        send_request(KIND_HDR, rand64(), rand64(), 5'd5);
        send_request(KIND_BODY, '0, '0, 5'd16);
        send_request(KIND_FIN, '1, '1, 5'd31);
        send_request(KIND_FIN, '0, '0, 5'd0);
        send_request(KIND_BODY, '1, '1, 5'd0);
        send_request(KIND_HDR, {4{16'haaaa}}, {4{16'haaaa}}, 5'd16);
        send_request(KIND_BODY, {4{16'h5555}}, {4{16'h5555}}, 5'd16);
        send_request(KIND_FIN, rand64(), rand64(), 5'd16);
    endtask

    task automatic test_key_extremes();
        logic [BLK_W-1:0] keys[4];
        keys[0] = '1;
        keys[1] = {1'b1, {(BLK_W-1){1'b0}}};   // multiplicative identity
        keys[2] = {{(BLK_W-1){1'b0}}, 1'b1};   // highest power of x: reduces on the first step
        keys[3] = '0;
        foreach (keys[i]) begin
            set_subkey(keys[i]);
            send_request(KIND_HDR, '1, '1, 5'd16);
            send_request(KIND_BODY, rand64(), rand64(), 5'd7);
            send_request(KIND_BODY, '1, '1, 5'd16);
            send_request(KIND_FIN, '0, '0, 5'd0);
        end
    endtask

    task automatic test_random_messages();
        int unsigned start;
        start = hashed_items;
        for (int p = 0; p < 6; p++) begin
            set_subkey({rand64(), rand64()});
            idle_on = (p != 2);   // one phase at full rate on both sides
            while (hashed_items - start < (p + 1) * RAND_ITEMS / 6)
                send_message($urandom_range(0, 3), $urandom_range(0, 6));
        end
        idle_on = 1'b1;
        // a lone high-half write keeps the low half in place
        wait_idle();
        write_cfg(CFG_KEY_HI, rand64());
        send_message(2, 3);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_key_extremes();
        test_random_messages();
        wait_idle();
        if (failures == 0) begin
            $display("[ghash_accumulator] OK");
        end else begin
            $display("[ghash_accumulator] ERROR");
        end
        $finish;
    end

endmodule
